// ===== hw/rtl/bcomp_pkg.sv =====
// ============================================================================
// bcomp_pkg
// Shared types, register indexes and helpers of the barometer compensation.
// ============================================================================
package bcomp_pkg;

    localparam int unsigned DivSteps = 32;
    localparam int unsigned DivSideW = 52;

    typedef enum logic [2:0] {
        REG_AC1_AC2   = 3'd0,
        REG_AC3_AC4   = 3'd1,
        REG_AC5_AC6   = 3'd2,
        REG_B1_B2     = 3'd3,
        REG_MC_MD     = 3'd4,
        REG_OVERSAMP  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic [17:0]        pressure_pa;
        logic               div_error;
    } out_item_t;

    typedef struct packed {
        logic [31:0] ac1_ac2;
        logic [31:0] ac3_ac4;
        logic [31:0] ac5_ac6;
        logic [31:0] b1_b2;
        logic [31:0] mc_md;
        logic [1:0]  oss;
    } cal_t;

    // divider slot: unsigned magnitude division with sign fixup
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] dvs;
        logic        neg;
    } div_t;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        sext16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
        asr = 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        mul = p[31:0];
    endfunction

    function automatic logic [31:0] mag(input logic [31:0] x);
        mag = x[31] ? 32'(-x) : x;
    endfunction

    function automatic div_t div_start(input logic [31:0] a, input logic [31:0] b,
                                       input logic sgn);
        div_t d;
        d.rem = '0;
        d.quo = sgn ? mag(a) : a;
        d.dvs = sgn ? mag(b) : b;
        d.neg = sgn & (a[31] ^ b[31]);
        div_start = d;
    endfunction

    // one restoring step
    function automatic div_t div_step(input div_t d);
        div_t  r;
        logic [32:0] t;
        r = d;
        t = {d.rem, d.quo[31]};
        if (t >= {1'b0, d.dvs})
        begin
            t = t - {1'b0, d.dvs};
            r.quo = {d.quo[30:0], 1'b1};
        end
        else
        begin
            r.quo = {d.quo[30:0], 1'b0};
        end
        r.rem = t[31:0];
        div_step = r;
    endfunction

    function automatic logic [31:0] div_result(input div_t d);
        div_result = d.neg ? 32'(-d.quo) : d.quo;
    endfunction

endpackage

// ===== hw/rtl/barometer_compensation_top.sv =====
// ============================================================================
// barometer_compensation_top
// Datasheet integer temperature/pressure compensation of a barometer.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_stall/in_item) carries raw temperature and
//   raw pressure; output channel (out_valid/out_stall/out_item) carries the
//   compensated temperature, pressure and a divide error flag.
//   Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
//   calibration words; write only while no item is in flight.
//   Throughput: one item per cycle unless the pipe is frozen. Each item
//   passes through the two pipelined 32-step dividers (temperature
//   quotient and pressure quotient) plus the nine register stages
//   around them.
//   The pipeline advances as one unit: when the output holds an item and
//   out_stall is high, the whole pipe freezes and in_stall goes high.
//   Reset empties the pipeline and loads calibration zeros and
//   oversampling 3.
// ============================================================================
module barometer_compensation_top
    import bcomp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cal_t        cal_reg;
    logic        advance;
    logic        tv;
    logic [31:0] b5, t;
    logic        terr;
    logic [18:0] up;

    assign advance   = !(out_valid && out_stall);
    assign in_stall  = !advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '{ac1_ac2: 32'd0, ac3_ac4: 32'd0, ac5_ac6: 32'd0,
                         b1_b2: 32'd0, mc_md: 32'd0, oss: 2'd3};
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_AC1_AC2:  cal_reg.ac1_ac2 <= cfg_data;
                REG_AC3_AC4:  cal_reg.ac3_ac4 <= cfg_data;
                REG_AC5_AC6:  cal_reg.ac5_ac6 <= cfg_data;
                REG_B1_B2:    cal_reg.b1_b2   <= cfg_data;
                REG_MC_MD:    cal_reg.mc_md   <= cfg_data;
                REG_OVERSAMP: cal_reg.oss     <= cfg_data[1:0];
                default:      ;
            endcase
        end
    end

    bcomp_temp u_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cal       (cal_reg),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .out_valid (tv),
        .b5        (b5),
        .t         (t),
        .err       (terr),
        .up        (up)
    );

    bcomp_pres u_pres (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cal       (cal_reg),
        .in_valid  (tv),
        .b5        (b5),
        .t         (t),
        .err       (terr),
        .up        (up),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

// ===== hw/rtl/bcomp_div.sv =====
// ============================================================================
// bcomp_div
// Pipelined 32-bit divider, one quotient bit per stage, payload carried along.
// ============================================================================
module bcomp_div
    import bcomp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  div_t                in_div,
    input  logic [DivSideW-1:0] in_side,
    output logic                out_valid,
    output div_t                out_div,
    output logic [DivSideW-1:0] out_side
);

    logic                v_reg    [DivSteps];
    div_t                d_reg    [DivSteps];
    logic [DivSideW-1:0] s_reg    [DivSteps];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DivSteps; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < DivSteps; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d_reg[0] <= div_step(in_div);
            s_reg[0] <= in_side;
            for (int i = 1; i < DivSteps; i++)
            begin
                d_reg[i] <= div_step(d_reg[i-1]);
                s_reg[i] <= s_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[DivSteps-1];
    assign out_div   = d_reg[DivSteps-1];
    assign out_side  = s_reg[DivSteps-1];

endmodule

// ===== hw/rtl/bcomp_temp.sv =====
// ============================================================================
// bcomp_temp
// Temperature path: X1, divisor check, MC*2^11/(X1+MD) division, B5 and T.
// ============================================================================
module bcomp_temp
    import bcomp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  cal_t        cal,
    input  logic        in_valid,
    input  in_item_t    in_item,
    output logic        out_valid,
    output logic [31:0] b5,
    output logic [31:0] t,
    output logic        err,
    output logic [18:0] up
);

    logic        v1_reg;
    logic [31:0] x1m_reg;
    logic [18:0] up1_reg;
    logic        v2_reg;
    logic [31:0] x1_reg;
    logic [18:0] up2_reg;
    div_t        d_in;
    logic        dv_out;
    div_t        d_out;
    logic [DivSideW-1:0] s_out;
    logic [31:0] x2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x1m_reg <= mul({16'd0, in_item.raw_temperature} - {16'd0, cal.ac5_ac6[15:0]},
                           {16'd0, cal.ac5_ac6[31:16]});
            up1_reg <= in_item.raw_pressure;
            x1_reg  <= asr(x1m_reg, 5'd15);
            up2_reg <= up1_reg;
        end
    end

    logic [31:0] den;
    logic        den_zero;
    assign den      = x1_reg + sext16(cal.mc_md[15:0]);
    assign den_zero = (den == 32'd0);
    assign d_in     = div_start({sext16(cal.mc_md[31:16])} << 11,
                                den_zero ? 32'd1 : den, 1'b1);

    bcomp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (v2_reg),
        .in_div    (d_in),
        .in_side   ({x1_reg, den_zero, up2_reg}),
        .out_valid (dv_out),
        .out_div   (d_out),
        .out_side  (s_out)
    );

    assign x2        = div_result(d_out);
    assign out_valid = dv_out;
    assign b5        = s_out[DivSideW-1 -: 32] + x2;
    assign t         = asr(b5 + 32'd8, 5'd4);
    assign err       = s_out[19];
    assign up        = s_out[18:0];

endmodule

// ===== hw/rtl/bcomp_pres.sv =====
// ============================================================================
// bcomp_pres
// Pressure path: B6 terms, B3, B4, B7, unsigned quotient and final polynomial.
// ============================================================================
module bcomp_pres
    import bcomp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  cal_t        cal,
    input  logic        in_valid,
    input  logic [31:0] b5,
    input  logic [31:0] t,
    input  logic        err,
    input  logic [18:0] up,
    output logic        out_valid,
    output out_item_t   out_item
);

    // stage a: b6, b6*b6, ac2*b6, ac3*b6
    logic        va_reg, vb_reg, vc_reg, vd_reg, vf_reg, vg_reg, vh_reg;
    logic [31:0] ta_reg, tb_reg, tc_reg, td_reg, tf_reg, tg_reg, th_reg;
    logic        ea_reg, eb_reg, ec_reg, ed_reg, ef_reg, eg_reg, eh_reg;
    logic [18:0] ua_reg, ub_reg, uc_reg;
    logic [31:0] sq_reg, a2_reg, a3_reg;
    logic [31:0] m1_reg, m2_reg, x2b_reg, x1c_reg;
    logic [31:0] b3_reg, x3_reg, b4_reg, b7_reg;
    logic [31:0] p_reg, pq_reg, pm_reg;
    logic [31:0] x2b_g_reg, pp_reg, x1h_reg, x2h_reg, pres;
    logic [31:0] sq12;
    logic [1:0]  oss;
    div_t        d_in, d_out;
    logic        dv_out;
    logic [DivSideW-1:0] s_out;

    assign oss  = cal.oss;
    assign sq12 = asr(sq_reg, 5'd12);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
            vh_reg <= 1'b0;
        end
        else if (advance)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            vf_reg <= dv_out;
            vg_reg <= vf_reg;
            vh_reg <= vg_reg;
        end
    end

    logic [31:0] b6;
    assign b6 = b5 - 32'd4000;

    logic [31:0] x3s, b3n, x3b;
    assign x3s = asr(m1_reg, 5'd11) + x2b_reg;
    assign b3n = ((mul(sext16(cal.ac1_ac2[31:16]), 32'd4) + x3s) << oss) + 32'd2;
    assign x3b = asr(x1c_reg + asr(m2_reg, 5'd16) + 32'd2, 5'd2);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // a
            sq_reg <= mul(b6, b6);
            a2_reg <= mul(sext16(cal.ac1_ac2[15:0]), b6);
            a3_reg <= mul(sext16(cal.ac3_ac4[31:16]), b6);
            ta_reg <= t;
            ea_reg <= err;
            ua_reg <= up;
            // b
            m1_reg  <= mul(sext16(cal.b1_b2[15:0]), sq12);
            m2_reg  <= mul(sext16(cal.b1_b2[31:16]), sq12);
            x2b_reg <= asr(a2_reg, 5'd11);
            x1c_reg <= asr(a3_reg, 5'd13);
            tb_reg  <= ta_reg;
            eb_reg  <= ea_reg;
            ub_reg  <= ua_reg;
            // c
            b3_reg <= asr(b3n + {30'd0, b3n[31], 1'b0} + {31'd0, b3n[31]}, 5'd2);
            x3_reg <= x3b;
            tc_reg <= tb_reg;
            ec_reg <= eb_reg;
            uc_reg <= ub_reg;
            // d
            b4_reg <= mul({16'd0, cal.ac3_ac4[15:0]}, x3_reg + 32'd32768) >> 15;
            b7_reg <= mul({13'd0, uc_reg} - b3_reg, 32'd50000 >> oss);
            td_reg <= tc_reg;
            ed_reg <= ec_reg;
        end
    end

    // b3 rounding above: sdiv by 4 truncates toward zero, so bias negatives by 3

    logic b4_zero, big;
    assign b4_zero = (b4_reg == 32'd0);
    assign big     = b7_reg[31];
    assign d_in    = div_start(big ? b7_reg : (b7_reg << 1), b4_zero ? 32'd1 : b4_reg, 1'b0);

    bcomp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (vd_reg),
        .in_div    (d_in),
        .in_side   ({18'd0, td_reg, ed_reg | b4_zero, big}),
        .out_valid (dv_out),
        .out_div   (d_out),
        .out_side  (s_out)
    );

    logic [31:0] pdiv;
    assign pdiv = s_out[0] ? (d_out.quo << 1) : d_out.quo;

    logic [31:0] p8;
    assign p8 = asr(p_reg, 5'd8);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // f
            p_reg  <= pdiv;
            tf_reg <= s_out[33:2];
            ef_reg <= s_out[1];
            // g
            pq_reg <= mul(p8, p8);
            pm_reg <= p_reg;
            x2b_g_reg <= asr(mul(32'hFFFF_E343, p_reg), 5'd16);
            tg_reg <= tf_reg;
            eg_reg <= ef_reg;
            // h
            th_reg <= tg_reg;
            eh_reg <= eg_reg;
            pp_reg <= pm_reg;
            x1h_reg <= asr(mul(pq_reg, 32'd3038), 5'd16);
            x2h_reg <= x2b_g_reg;
        end
    end

    assign pres = pp_reg + asr(x1h_reg + x2h_reg + 32'd3791, 5'd4);

    always_comb
    begin
        out_item = '0;
        out_item.div_error = eh_reg;
        if (!eh_reg)
        begin
            if ($signed(th_reg) < -32'sd32768)
                out_item.temperature_tenths = 16'sh8000;
            else if ($signed(th_reg) > 32'sd32767)
                out_item.temperature_tenths = 16'sh7FFF;
            else
                out_item.temperature_tenths = th_reg[15:0];
            if (pres[31])
                out_item.pressure_pa = '0;
            else if (pres > 32'd262143)
                out_item.pressure_pa = 18'h3FFFF;
            else
                out_item.pressure_pa = pres[17:0];
        end
    end

    assign out_valid = vh_reg;

endmodule

// ===== hw/rtl/bcomp_checker.sv =====
// ============================================================================
// bcomp_checker
// Port-level checks of the barometer compensation block.
// ============================================================================
module bcomp_checker
    import bcomp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_stall,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_item
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled item changed");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.div_error |->
            out_item.pressure_pa == 18'd0 && out_item.temperature_tenths == 16'sd0)
        else $error("error item not zeroed");

    a_backpress: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

endmodule

bind barometer_compensation_top bcomp_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
